>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the servo bus framer.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low
`define SBCF_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("servo framer check failed");

// Same, on the block clock and reset
`define SBCF_ASSERT(lbl, prop) \
	`SBCF_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

>>> hw/rtl/sbcf_pkg.sv
// Package of the servo bus command framer: operation codes, packet constants,
// command record and result record types. No dependencies.
package sbcf_pkg;

	// Operation codes of an input item
	localparam logic [2:0] OP_TORQUE    = 3'd0;
	localparam logic [2:0] OP_POSITION  = 3'd1;
	localparam logic [2:0] OP_POS_ACCEL = 3'd2;
	localparam logic [2:0] OP_MOTOR     = 3'd3;
	localparam logic [2:0] OP_READ      = 3'd4;
	localparam logic [2:0] OP_GROUP     = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GOAL_POS_ADDR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GOAL_SPEED_ADDR = 2'd2;

	localparam logic [7:0] RST_TORQUE_ADDR = 8'd40;
	localparam logic [7:0] RST_GOAL_POS_ADDR = 8'd42;
	localparam logic [7:0] RST_GOAL_SPEED_ADDR = 8'd46;

	// Packet bytes
	localparam logic [7:0] HDR_BYTE      = 8'hFF;
	localparam logic [7:0] BCAST_ID      = 8'hFE;
	localparam logic [7:0] INSTR_READ    = 8'h02;
	localparam logic [7:0] INSTR_WRITE   = 8'h03;
	localparam logic [7:0] INSTR_SYNC    = 8'h83;
	localparam logic [7:0] LEN_SHORT     = 8'h04;
	localparam logic [7:0] LEN_MOTOR     = 8'h05;
	localparam logic [7:0] LEN_POSITION  = 8'h09;
	localparam logic [7:0] ACCEL_ADDR    = 8'h29;
	localparam logic [7:0] PRESENT_POS   = 8'h38;
	localparam logic [7:0] READ_LEN      = 8'h02;
	localparam logic [7:0] SYNC_ADDR     = 8'h2A;
	localparam logic [7:0] SYNC_DATA_LEN = 8'h06;
	localparam logic [7:0] ENTRY_BYTES   = 8'd7;
	localparam logic [7:0] SYNC_LEN_BASE = 8'd4;
	localparam logic [15:0] DIR_BIT      = 16'h8000;

	// Longest byte list ahead of the checksum (group header plus one entry)
	localparam int BODY_BYTES = 14;
	localparam int IDX_W = 4;

	// Command record handed from the front to the back
	typedef struct packed {
		logic [BODY_BYTES-1:0][7:0] body;   // bytes in transmit order
		logic [IDX_W-1:0]           nbytes; // valid bytes in body
		logic                       hdr;    // body opens with FF FF, restart the sum
		logic                       chk;    // append the checksum byte
	} cmd_t;

	// One result item
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       packet_end;
		logic       run_last;
	} out_t;

endpackage

>>> hw/rtl/sbcf_fifo.sv
// Small synchronous queue of generic width and depth.
// Standalone; used for the command queue and the result queue.
module sbcf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store the entry on a push transfer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/sbcf_front.sv
// Front end of the servo bus framer: accepts commands, tracks group writes and
// builds the byte list of each command. Depends on sbcf_pkg.
module sbcf_front #(
	parameter int MAX_GROUP_ENTRIES = 35
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command input
	input  logic                           push,
	input  logic                           full,
	input  logic [2:0]                     operation,
	input  logic [7:0]                     servo_id,
	input  logic [15:0]                    goal_position,
	input  logic [15:0]                    speed_value,
	input  logic [7:0]                     accel_value,
	input  logic                           torque_on,
	input  logic [5:0]                     group_count,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sbcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	// command queue side
	output logic                           cmd_push,
	output sbcf_pkg::cmd_t                 cmd
);

	localparam logic [5:0] MAX_CNT = 6'(MAX_GROUP_ENTRIES);

	logic [7:0]  torque_addr_q;
	logic [7:0]  goal_pos_addr_q;
	logic [7:0]  goal_speed_addr_q;
	logic [5:0]  entries_left_q;

	logic        accept;
	logic        known_op;
	logic        grp_first;
	logic [5:0]  cnt_cl;
	logic [5:0]  el_start;
	logic [5:0]  el_next;
	logic [7:0]  grp_len;
	logic [15:0] motor_spd;
	logic [3:0]  base;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign known_op  = (operation <= sbcf_pkg::OP_GROUP);
	assign cmd_push  = accept && known_op;

	// Clamp the group count and work out the entry bookkeeping
	always_comb begin
		if (group_count == 6'd0) begin
			cnt_cl = 6'd1;
		end else if (group_count > MAX_CNT) begin
			cnt_cl = MAX_CNT;
		end else begin
			cnt_cl = group_count;
		end
		grp_first = (entries_left_q == 6'd0);
		el_start  = grp_first ? cnt_cl : entries_left_q;
		el_next   = el_start - 6'd1;
		grp_len   = {2'b00, cnt_cl} * sbcf_pkg::ENTRY_BYTES + sbcf_pkg::SYNC_LEN_BASE;
		base      = grp_first ? 4'd7 : 4'd0;
	end

	// Convert a two's-complement speed to sign-magnitude
	always_comb begin
		if (speed_value[15]) begin
			motor_spd = (~speed_value + 16'd1) | sbcf_pkg::DIR_BIT;
		end else begin
			motor_spd = speed_value;
		end
	end

	// Build the byte list of the command
	always_comb begin
		cmd = '0;
		unique case (operation)
			sbcf_pkg::OP_TORQUE: begin
				cmd.hdr     = 1'b1;
				cmd.chk     = 1'b1;
				cmd.nbytes  = 4'd7;
				cmd.body[0] = sbcf_pkg::HDR_BYTE;
				cmd.body[1] = sbcf_pkg::HDR_BYTE;
				cmd.body[2] = servo_id;
				cmd.body[3] = sbcf_pkg::LEN_SHORT;
				cmd.body[4] = sbcf_pkg::INSTR_WRITE;
				cmd.body[5] = torque_addr_q;
				cmd.body[6] = {7'd0, torque_on};
			end
			sbcf_pkg::OP_POSITION: begin
				cmd.hdr      = 1'b1;
				cmd.chk      = 1'b1;
				cmd.nbytes   = 4'd12;
				cmd.body[0]  = sbcf_pkg::HDR_BYTE;
				cmd.body[1]  = sbcf_pkg::HDR_BYTE;
				cmd.body[2]  = servo_id;
				cmd.body[3]  = sbcf_pkg::LEN_POSITION;
				cmd.body[4]  = sbcf_pkg::INSTR_WRITE;
				cmd.body[5]  = goal_pos_addr_q;
				cmd.body[6]  = goal_position[7:0];
				cmd.body[7]  = goal_position[15:8];
				cmd.body[8]  = 8'd0;
				cmd.body[9]  = 8'd0;
				cmd.body[10] = speed_value[7:0];
				cmd.body[11] = speed_value[15:8];
			end
			sbcf_pkg::OP_POS_ACCEL: begin
				cmd.hdr      = 1'b1;
				cmd.chk      = 1'b1;
				cmd.nbytes   = 4'd13;
				cmd.body[0]  = sbcf_pkg::HDR_BYTE;
				cmd.body[1]  = sbcf_pkg::HDR_BYTE;
				cmd.body[2]  = servo_id;
				cmd.body[3]  = sbcf_pkg::LEN_POSITION;
				cmd.body[4]  = sbcf_pkg::INSTR_WRITE;
				cmd.body[5]  = sbcf_pkg::ACCEL_ADDR;
				cmd.body[6]  = accel_value;
				cmd.body[7]  = goal_position[7:0];
				cmd.body[8]  = goal_position[15:8];
				cmd.body[9]  = 8'd0;
				cmd.body[10] = 8'd0;
				cmd.body[11] = speed_value[7:0];
				cmd.body[12] = speed_value[15:8];
			end
			sbcf_pkg::OP_MOTOR: begin
				cmd.hdr     = 1'b1;
				cmd.chk     = 1'b1;
				cmd.nbytes  = 4'd8;
				cmd.body[0] = sbcf_pkg::HDR_BYTE;
				cmd.body[1] = sbcf_pkg::HDR_BYTE;
				cmd.body[2] = servo_id;
				cmd.body[3] = sbcf_pkg::LEN_MOTOR;
				cmd.body[4] = sbcf_pkg::INSTR_WRITE;
				cmd.body[5] = goal_speed_addr_q;
				cmd.body[6] = motor_spd[7:0];
				cmd.body[7] = motor_spd[15:8];
			end
			sbcf_pkg::OP_READ: begin
				cmd.hdr     = 1'b1;
				cmd.chk     = 1'b1;
				cmd.nbytes  = 4'd7;
				cmd.body[0] = sbcf_pkg::HDR_BYTE;
				cmd.body[1] = sbcf_pkg::HDR_BYTE;
				cmd.body[2] = servo_id;
				cmd.body[3] = sbcf_pkg::LEN_SHORT;
				cmd.body[4] = sbcf_pkg::INSTR_READ;
				cmd.body[5] = sbcf_pkg::PRESENT_POS;
				cmd.body[6] = sbcf_pkg::READ_LEN;
			end
			sbcf_pkg::OP_GROUP: begin
				cmd.hdr    = grp_first;
				cmd.chk    = (el_next == 6'd0);
				cmd.nbytes = base + 4'd7;
				if (grp_first) begin
					cmd.body[0] = sbcf_pkg::HDR_BYTE;
					cmd.body[1] = sbcf_pkg::HDR_BYTE;
					cmd.body[2] = sbcf_pkg::BCAST_ID;
					cmd.body[3] = grp_len;
					cmd.body[4] = sbcf_pkg::INSTR_SYNC;
					cmd.body[5] = sbcf_pkg::SYNC_ADDR;
					cmd.body[6] = sbcf_pkg::SYNC_DATA_LEN;
				end
				cmd.body[base]        = servo_id;
				cmd.body[base + 4'd1] = goal_position[7:0];
				cmd.body[base + 4'd2] = goal_position[15:8];
				cmd.body[base + 4'd3] = 8'd0;
				cmd.body[base + 4'd4] = 8'd0;
				cmd.body[base + 4'd5] = speed_value[7:0];
				cmd.body[base + 4'd6] = speed_value[15:8];
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Hold configuration and the group entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_addr_q     <= sbcf_pkg::RST_TORQUE_ADDR;
			goal_pos_addr_q   <= sbcf_pkg::RST_GOAL_POS_ADDR;
			goal_speed_addr_q <= sbcf_pkg::RST_GOAL_SPEED_ADDR;
			entries_left_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sbcf_pkg::CFG_TORQUE_ADDR:     torque_addr_q <= cfg_data;
					sbcf_pkg::CFG_GOAL_POS_ADDR:   goal_pos_addr_q <= cfg_data;
					sbcf_pkg::CFG_GOAL_SPEED_ADDR: goal_speed_addr_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd_push) begin
				if (operation == sbcf_pkg::OP_GROUP) begin
					entries_left_q <= el_next;
				end else begin
					entries_left_q <= '0;
				end
			end
		end
	end

endmodule

>>> hw/rtl/sbcf_back.sv
// Back end of the servo bus framer: walks one command's byte list a byte per
// cycle while the result queue has room; appends the checksum. Depends on sbcf_pkg.
module sbcf_back (
	input  logic           clk,
	input  logic           arst_n,
	// command queue side
	input  sbcf_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	// result queue side
	input  logic           out_full,
	output logic           out_push,
	output sbcf_pkg::out_t out_data
);

	logic [sbcf_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                 sum_q;

	logic                       go;
	logic                       is_chk;
	logic                       last;
	logic [sbcf_pkg::IDX_W-1:0] total;
	logic [sbcf_pkg::IDX_W-1:0] sel;
	logic [7:0]                 cur_byte;

	// Pick the current byte
	always_comb begin
		is_chk   = cmd.chk && (idx_q == cmd.nbytes);
		total    = cmd.nbytes + {{(sbcf_pkg::IDX_W-1){1'b0}}, cmd.chk};
		last     = (idx_q == total - 1'b1);
		sel      = is_chk ? '0 : idx_q;
		cur_byte = is_chk ? ~sum_q : cmd.body[sel];
		go       = !cmd_empty && !out_full;
	end

	assign out_push            = go;
	assign cmd_pop             = go && last;
	assign out_data.tx_byte    = cur_byte;
	assign out_data.packet_end = is_chk;
	assign out_data.run_last   = last;

	// Advance through the list and keep the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
		end else if (go) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
			if (cmd.hdr && (idx_q < 4'd2)) begin
				sum_q <= '0;
			end else if (!is_chk) begin
				sum_q <= sum_q + cur_byte;
			end
		end
	end

endmodule

>>> hw/rtl/servo_bus_command_framer_unit.sv
// Top level of the servo bus command framer: front end, command queue, byte
// sequencer and result queue. Depends on sbcf_pkg, sbcf_fifo, sbcf_front, sbcf_back.
//
//   channel   handshake              payload
//   command   push / full            operation servo_id goal_position speed_value
//                                    accel_value torque_on group_count
//   result    empty / pop            tx_byte packet_end run_last
//   config    cfg_valid / cfg_ready  cfg_index cfg_data
//
// The front takes a command every cycle while the two-entry command queue has room.
// The byte sequencer sends one byte per cycle while the result queue has room; an item
// is its byte list plus a checksum byte where one is appended, 7 to 15 bytes in all.
// Results wait in a two-entry queue; a stalled pop backs up into the sequencer.
// Reset is asynchronous and clears all control state; the block is ready at once.
module servo_bus_command_framer_unit #(
	parameter int MAX_GROUP_ENTRIES = 35
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [2:0]                     operation,
	input  logic [7:0]                     servo_id,
	input  logic [15:0]                    goal_position,
	input  logic [15:0]                    speed_value,
	input  logic [7:0]                     accel_value,
	input  logic                           torque_on,
	input  logic [5:0]                     group_count,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     tx_byte,
	output logic                           packet_end,
	output logic                           run_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sbcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	sbcf_pkg::cmd_t cmd_in;
	sbcf_pkg::cmd_t cmd_out;
	sbcf_pkg::out_t res_in;
	sbcf_pkg::out_t res_out;
	logic           cmd_push;
	logic           cmd_pop;
	logic           cmd_empty;
	logic           out_push;
	logic           out_full;

	// Accept and classify commands
	sbcf_front #(
		.MAX_GROUP_ENTRIES(MAX_GROUP_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.servo_id     (servo_id),
		.goal_position(goal_position),
		.speed_value  (speed_value),
		.accel_value  (accel_value),
		.torque_on    (torque_on),
		.group_count  (group_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	// Decouple front and back
	sbcf_fifo #(
		.WIDTH($bits(sbcf_pkg::cmd_t)),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	// Emit packet bytes
	sbcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (res_in)
	);

	// Hold results for the consumer
	sbcf_fifo #(
		.WIDTH($bits(sbcf_pkg::out_t)),
		.DEPTH(2)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (res_in),
		.full  (out_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign tx_byte    = res_out.tx_byte;
	assign packet_end = res_out.packet_end;
	assign run_last   = res_out.run_last;

endmodule

>>> hw/rtl/sbcf_checker.sv
// Port-level checker of the servo bus command framer, bound to the top level.
// Depends on sbcf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] tx_byte,
	input logic       packet_end,
	input logic       run_last
);

	logic after_end_q;
	logic out_xfer;

	assign out_xfer = pop && !empty;

	// Track whether the next result transfer opens a new packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_end_q <= 1'b1;
		end else if (out_xfer) begin
			after_end_q <= packet_end;
		end
	end

	// A checksum byte always closes the bytes of its command
	`SBCF_ASSERT(a_end_is_last, !empty && packet_end |-> run_last)
	// A packet after a checksum, or the first after reset, starts with the header
	`SBCF_ASSERT(a_hdr_after_end, out_xfer && after_end_q |-> tx_byte == sbcf_pkg::HDR_BYTE)
	// A waiting result stays until transferred
	`SBCF_ASSERT(a_res_hold, !empty && !pop |=> !empty)
	// A stalled result keeps its byte
	`SBCF_ASSERT(a_res_stable, !empty && !pop |=> $stable(tx_byte) && $stable(packet_end))

endmodule

bind servo_bus_command_framer_unit sbcf_checker u_sbcf_checker (.*);

>>> tb/servo_bus_command_framer_unit_tb.sv
// Self-checking testbench for servo_bus_command_framer_unit: servo commands in,
// packet bytes out, each byte checked against a local packet builder.
// Depends on sbcf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module servo_bus_command_framer_unit_tb;

	localparam int MAX_GROUP_ENTRIES = 35;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_PRINTED = 40;

	// Operation codes the block ignores
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [7:0]  id;
		logic [15:0] pos;
		logic [15:0] spd;
		logic [7:0]  acc;
		logic        ton;
		logic [5:0]  cnt;
	} servo_cmd_t;

	logic                           clk;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic [2:0]                     operation;
	logic [7:0]                     servo_id;
	logic [15:0]                    goal_position;
	logic [15:0]                    speed_value;
	logic [7:0]                     accel_value;
	logic                           torque_on;
	logic [5:0]                     group_count;
	logic                           empty;
	logic                           pop;
	logic [7:0]                     tx_byte;
	logic                           packet_end;
	logic                           run_last;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [sbcf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                     cfg_data;

	// Packet builder state and its copy of the registers
	logic [7:0] run_sum;
	logic [5:0] group_left;
	logic [7:0] torque_addr_m;
	logic [7:0] pos_addr_m;
	logic [7:0] speed_addr_m;

	sbcf_pkg::out_t tx_bytes_due[$];
	int             mismatch_count;
	int             tx_idle_pct;
	int             rx_idle_pct;
	int             quiet_cycles;
	logic           stall_req;

	servo_bus_command_framer_unit #(
		.MAX_GROUP_ENTRIES(MAX_GROUP_ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.servo_id(servo_id),
		.goal_position(goal_position),
		.speed_value(speed_value),
		.accel_value(accel_value),
		.torque_on(torque_on),
		.group_count(group_count),
		.empty(empty),
		.pop(pop),
		.tx_byte(tx_byte),
		.packet_end(packet_end),
		.run_last(run_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED)
			$display("ERROR @%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Packet builder: append bytes to the due list, keeping the running sum
	function automatic void put_byte(input logic [7:0] b, input logic is_end);
		tx_bytes_due.push_back('{tx_byte: b, packet_end: is_end, run_last: 1'b0});
	endfunction

	function automatic void put_summed(input logic [7:0] b);
		run_sum = run_sum + b;
		put_byte(b, 1'b0);
	endfunction

	function automatic void put_word(input logic [15:0] w);
		put_summed(w[7:0]);
		put_summed(w[15:8]);
	endfunction

	function automatic void put_header(input logic [7:0] id, input logic [7:0] len,
			input logic [7:0] instr);
		put_byte(sbcf_pkg::HDR_BYTE, 1'b0);
		put_byte(sbcf_pkg::HDR_BYTE, 1'b0);
		run_sum = 8'h00;
		put_summed(id);
		put_summed(len);
		put_summed(instr);
	endfunction

	function automatic void put_checksum();
		put_byte(~run_sum, 1'b1);
	endfunction

	// Work out the bytes one accepted command causes
	function automatic void frame_command(input servo_cmd_t c);
		int          first;
		logic [15:0] mag;
		logic [5:0]  n;
		first = tx_bytes_due.size();
		if (c.op <= sbcf_pkg::OP_GROUP) begin
			// any single command abandons an open group
			if (c.op != sbcf_pkg::OP_GROUP)
				group_left = 6'd0;
			case (c.op)
				sbcf_pkg::OP_TORQUE: begin
					put_header(c.id, sbcf_pkg::LEN_SHORT, sbcf_pkg::INSTR_WRITE);
					put_summed(torque_addr_m);
					put_summed({7'd0, c.ton});
					put_checksum();
				end
				sbcf_pkg::OP_POSITION: begin
					put_header(c.id, sbcf_pkg::LEN_POSITION, sbcf_pkg::INSTR_WRITE);
					put_summed(pos_addr_m);
					put_word(c.pos);
					put_word(16'h0000);
					put_word(c.spd);
					put_checksum();
				end
				sbcf_pkg::OP_POS_ACCEL: begin
					put_header(c.id, sbcf_pkg::LEN_POSITION, sbcf_pkg::INSTR_WRITE);
					put_summed(sbcf_pkg::ACCEL_ADDR);
					put_summed(c.acc);
					put_word(c.pos);
					put_word(16'h0000);
					put_word(c.spd);
					put_checksum();
				end
				sbcf_pkg::OP_MOTOR: begin
					// two's complement to sign-magnitude, direction in bit 15
					mag = c.spd;
					if (c.spd[15])
						mag = (~c.spd + 16'd1) | sbcf_pkg::DIR_BIT;
					put_header(c.id, sbcf_pkg::LEN_MOTOR, sbcf_pkg::INSTR_WRITE);
					put_summed(speed_addr_m);
					put_word(mag);
					put_checksum();
				end
				sbcf_pkg::OP_READ: begin
					put_header(c.id, sbcf_pkg::LEN_SHORT, sbcf_pkg::INSTR_READ);
					put_summed(sbcf_pkg::PRESENT_POS);
					put_summed(sbcf_pkg::READ_LEN);
					put_checksum();
				end
				default: begin
					if (group_left == 6'd0) begin
						n = c.cnt;
						if (n < 6'd1)
							n = 6'd1;
						if (n > 6'(MAX_GROUP_ENTRIES))
							n = 6'(MAX_GROUP_ENTRIES);
						put_header(sbcf_pkg::BCAST_ID,
							{2'b00, n} * sbcf_pkg::ENTRY_BYTES + sbcf_pkg::SYNC_LEN_BASE,
							sbcf_pkg::INSTR_SYNC);
						put_summed(sbcf_pkg::SYNC_ADDR);
						put_summed(sbcf_pkg::SYNC_DATA_LEN);
						group_left = n;
					end
					put_summed(c.id);
					put_word(c.pos);
					put_word(16'h0000);
					put_word(c.spd);
					group_left = group_left - 6'd1;
					if (group_left == 6'd0)
						put_checksum();
				end
			endcase
			if (tx_bytes_due.size() > first)
				tx_bytes_due[tx_bytes_due.size()-1].run_last = 1'b1;
		end
	endfunction

	// Field values with the extremes favored
	function automatic logic [15:0] pick16();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic logic [7:0] pick8();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(8'hFF));
		endcase
	endfunction

	function automatic servo_cmd_t random_cmd(input logic [2:0] op);
		servo_cmd_t c;
		c.op = op;
		c.id = pick8();
		c.pos = pick16();
		c.spd = pick16();
		c.acc = pick8();
		c.ton = 1'($urandom_range(1));
		c.cnt = 6'($urandom_range(63));
		return c;
	endfunction

	// Offer one command, hold it until the transfer, then idle cycle by cycle
	task automatic send_command(input servo_cmd_t c);
		operation <= c.op;
		servo_id <= c.id;
		goal_position <= c.pos;
		speed_value <= c.spd;
		accel_value <= c.acc;
		torque_on <= c.ton;
		group_count <= c.cnt;
		push <= 1'b1;
		do @(posedge clk); while (full);
		frame_command(c);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
	endtask

	// One group sync write: the first entry carries the count
	task automatic group_run(input logic [5:0] count, input int entries);
		servo_cmd_t c;
		for (int i = 0; i < entries; i++) begin
			c = random_cmd(sbcf_pkg::OP_GROUP);
			if (i == 0)
				c.cnt = count;
			send_command(c);
		end
	endtask

	// Stop offering, wait for every due byte, then let in-flight work settle
	task automatic drain_results();
		push <= 1'b0;
		while (tx_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] torque_addr, input logic [7:0] pos_addr,
			input logic [7:0] speed_addr);
		logic [sbcf_pkg::CFG_IDX_W-1:0] sel [3];
		logic [7:0]                     val [3];
		sel[0] = sbcf_pkg::CFG_TORQUE_ADDR;
		sel[1] = sbcf_pkg::CFG_GOAL_POS_ADDR;
		sel[2] = sbcf_pkg::CFG_GOAL_SPEED_ADDR;
		val[0] = torque_addr;
		val[1] = pos_addr;
		val[2] = speed_addr;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= sel[i];
			cfg_data <= val[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			case (sel[i])
				sbcf_pkg::CFG_TORQUE_ADDR: torque_addr_m = val[i];
				sbcf_pkg::CFG_GOAL_POS_ADDR: pos_addr_m = val[i];
				default: speed_addr_m = val[i];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Every single-packet command, most at their field extremes, plus the ignored codes
	task automatic test_single_commands();
		servo_cmd_t  c;
		logic [15:0] speeds [4];
		speeds[0] = 16'h0000;
		speeds[1] = 16'h7FFF;
		speeds[2] = 16'hFFFF;
		speeds[3] = 16'h8000;
		c = random_cmd(sbcf_pkg::OP_TORQUE);
		c.ton = 1'b1;
		c.id = 8'hFF;
		send_command(c);
		c.ton = 1'b0;
		c.id = 8'h00;
		send_command(c);
		c = random_cmd(sbcf_pkg::OP_POSITION);
		c.pos = 16'h0000;
		c.spd = 16'hFFFF;
		send_command(c);
		c.pos = 16'hFFFF;
		c.spd = 16'h0000;
		send_command(c);
		c = random_cmd(sbcf_pkg::OP_POS_ACCEL);
		c.acc = 8'hFF;
		send_command(c);
		c.acc = 8'h00;
		send_command(c);
		// most negative speed has magnitude 0x8000
		for (int i = 0; i < 4; i++) begin
			c = random_cmd(sbcf_pkg::OP_MOTOR);
			c.spd = speeds[i];
			send_command(c);
		end
		send_command(random_cmd(sbcf_pkg::OP_READ));
		send_command(random_cmd(OP_UNUSED_LO));
		send_command(random_cmd(OP_UNUSED_HI));
	endtask

	// Group writes: single entry, zero count, full run, clamped count, abandon
	task automatic test_group_write();
		group_run(6'd1, 1);
		group_run(6'd0, 1);
		group_run(6'd3, 3);
		group_run(6'd63, 2);
		send_command(random_cmd(sbcf_pkg::OP_TORQUE));
		group_run(6'd2, 2);
	endtask

	// Hold off the result side so the block fills and pushes back on input
	task automatic test_output_backpressure();
		int saved_pct;
		saved_pct = tx_idle_pct;
		tx_idle_pct = 0;
		stall_req <= 1'b1;
		for (int i = 0; i < 6; i++)
			send_command(random_cmd(3'($urandom_range(sbcf_pkg::OP_TORQUE,
				sbcf_pkg::OP_READ))));
		group_run(6'd4, 4);
		tx_idle_pct = saved_pct;
	endtask

	// Mostly well-formed traffic: single commands and complete group runs,
	// with some abandoned groups and ignored codes mixed in
	task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct,
			input logic [7:0] torque_addr, input logic [7:0] pos_addr,
			input logic [7:0] speed_addr);
		int       sent;
		int       roll;
		int       entries;
		int       r;
		logic [5:0] count;
		drain_results();
		program_regs(torque_addr, pos_addr, speed_addr);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			if (roll < 35) begin
				r = $urandom_range(99);
				if (r < 5)
					count = 6'd0;
				else if (r < 9)
					count = 6'($urandom_range(MAX_GROUP_ENTRIES + 1, 63));
				else if (r < 13)
					count = 6'($urandom_range(20, MAX_GROUP_ENTRIES));
				else
					count = 6'($urandom_range(1, 4));
				entries = (count == 6'd0) ? 1 :
					(count > 6'(MAX_GROUP_ENTRIES)) ? MAX_GROUP_ENTRIES : int'(count);
				// broken run: cut short, then closed by a single command
				if (roll < 8 && entries > 1) begin
					entries = $urandom_range(1, entries - 1);
					group_run(count, entries);
					send_command(random_cmd(3'($urandom_range(sbcf_pkg::OP_TORQUE,
						sbcf_pkg::OP_READ))));
					sent += entries + 1;
				end else begin
					group_run(count, entries);
					sent += entries;
				end
			end else if (roll < 39) begin
				send_command(random_cmd(roll[0] ? OP_UNUSED_HI : OP_UNUSED_LO));
			end else begin
				send_command(random_cmd(3'($urandom_range(sbcf_pkg::OP_TORQUE,
					sbcf_pkg::OP_READ))));
				sent++;
			end
		end
	endtask

	// Result side: random pop, or a long hold-off on request
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_req) begin
				pop <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_req <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Compare each transfer out against the oldest due byte
	always @(posedge clk) begin : tx_check
		sbcf_pkg::out_t due;
		if (arst_n && pop && !empty) begin
			if (tx_bytes_due.size() == 0) begin
				report_mismatch($sformatf("byte %02h with nothing due", tx_byte));
			end else begin
				due = tx_bytes_due.pop_front();
				if (tx_byte !== due.tx_byte)
					report_mismatch($sformatf("tx_byte got %02h want %02h",
						tx_byte, due.tx_byte));
				if (packet_end !== due.packet_end)
					report_mismatch($sformatf("packet_end got %b want %b on byte %02h",
						packet_end, due.packet_end, due.tx_byte));
				if (run_last !== due.run_last)
					report_mismatch($sformatf("run_last got %b want %b on byte %02h",
						run_last, due.run_last, due.tx_byte));
			end
		end
	end

	// End the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		operation <= sbcf_pkg::OP_TORQUE;
		servo_id <= 8'h00;
		goal_position <= 16'h0000;
		speed_value <= 16'h0000;
		accel_value <= 8'h00;
		torque_on <= 1'b0;
		group_count <= 6'd0;
		cfg_valid <= 1'b0;
		cfg_index <= sbcf_pkg::CFG_TORQUE_ADDR;
		cfg_data <= 8'h00;
		stall_req <= 1'b0;
		quiet_cycles = 0;
		mismatch_count = 0;
		run_sum = 8'h00;
		group_left = 6'd0;
		torque_addr_m = sbcf_pkg::RST_TORQUE_ADDR;
		pos_addr_m = sbcf_pkg::RST_GOAL_POS_ADDR;
		speed_addr_m = sbcf_pkg::RST_GOAL_SPEED_ADDR;
		tx_idle_pct = 26;
		rx_idle_pct = 46;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_commands();
		test_group_write();
		test_output_backpressure();
		test_random_traffic(40, 26, 46, 8'h00, 8'h00, 8'h00);
		test_random_traffic(40, 46, 26, 8'hFF, 8'hFF, 8'hFF);
		test_random_traffic(40, 0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		drain_results();

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
